// ===== design/sst_pkg.sv =====
package sst_pkg;

  localparam int ATOM_COUNT_DEF      = 1024;
  localparam int THRESHOLD_COUNT_DEF = 4;
  localparam int COUNT_WIDTH_DEF     = 32;

  localparam int SPIN_W  = 16;
  localparam int ATOM_W  = 10;
  localparam int STEP_W  = 32;
  localparam int OUT_W   = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AZ   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TH0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TH1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TH2  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TH3  = 3'd7;

  localparam logic MODE_UNIAXIAL = 1'b0;
  localparam logic MODE_CUBIC    = 1'b1;

  // classified word handed from the classifier to the table stage
  typedef struct packed {
    logic                   vld;
    logic [ATOM_W-1:0]      atom;
    logic [STEP_W-1:0]      step;
    logic [2:0]             state;
    logic [1:0]             tidx;
    logic                   met;
    logic                   last;
  } cls_t;

endpackage

// ===== design/sst_ram.sv =====
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/sst_classify.sv =====
// Snaps a spin to its easy-axis state and checks each threshold.
// Stage 1: products / abs. Stage 2: sums. Stage 3: squares. Then one word
// per threshold is issued from stage 3.
module sst_classify #(
  parameter int ATOM_COUNT      = sst_pkg::ATOM_COUNT_DEF,
  parameter int THRESHOLD_COUNT = sst_pkg::THRESHOLD_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic [sst_pkg::ATOM_W-1:0]    atom_index,
  input  logic signed [15:0]            spin_x,
  input  logic signed [15:0]            spin_y,
  input  logic signed [15:0]            spin_z,
  input  logic                          is_magnetic,
  input  logic [sst_pkg::STEP_W-1:0]    time_step,
  input  logic                          mode,
  input  logic signed [15:0]            axis_x,
  input  logic signed [15:0]            axis_y,
  input  logic signed [15:0]            axis_z,
  input  logic signed [15:0]            thr [4],
  output logic                          busy,
  output sst_pkg::cls_t                 cls
);

  localparam int TC_W = (THRESHOLD_COUNT > 1) ? $clog2(THRESHOLD_COUNT) : 1;
  // spacing between samples; raised with a single threshold to keep table read-after-write apart
  localparam int GAP  = (THRESHOLD_COUNT > 1) ? THRESHOLD_COUNT : 2;

  // stage 1
  logic                 s1_vld;
  logic [sst_pkg::ATOM_W-1:0] s1_atom;
  logic [sst_pkg::STEP_W-1:0] s1_step;
  logic                 s1_mode;
  logic [2:0]           s1_sgn;
  logic [15:0]          s1_ax, s1_ay, s1_az;
  logic signed [31:0]   s1_px, s1_py, s1_pz;

  // stage 2
  logic                 s2_vld;
  logic [sst_pkg::ATOM_W-1:0] s2_atom;
  logic [sst_pkg::STEP_W-1:0] s2_step;
  logic                 s2_mode;
  logic [2:0]           s2_state;
  logic [17:0]          s2_sum;
  logic [33:0]          s2_dabs;

  // stage 3 (held while issuing)
  logic                 s3_vld;
  logic [sst_pkg::ATOM_W-1:0] s3_atom;
  logic [sst_pkg::STEP_W-1:0] s3_step;
  logic                 s3_mode;
  logic [2:0]           s3_state;
  logic [35:0]          s3_sq;
  logic [33:0]          s3_dabs;
  logic [TC_W-1:0]      s3_t;

  logic                 accept;
  logic [1:0]           hold_cnt;
  logic signed [33:0]   dsum;
  logic signed [15:0]   th_cur;
  logic [31:0]          th_sq;
  logic [33:0]          th_sq3;
  logic                 met_c;
  logic                 s3_done;

  // the spacing counter holds off intake, so stage 3 frees up as the next sample arrives
  assign s3_done = s3_vld && (s3_t == TC_W'(THRESHOLD_COUNT - 1));
  assign busy    = (hold_cnt != 2'd0);
  assign accept  = in_vld && is_magnetic &&
                   (32'(atom_index) < 32'(ATOM_COUNT));

  // intake spacing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_cnt <= '0;
    end else if (accept) begin
      hold_cnt <= 2'(GAP - 1);
    end else if (hold_cnt != 2'd0) begin
      hold_cnt <= hold_cnt - 2'd1;
    end
  end

  // stage 1: abs values and axis products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
    s1_atom <= atom_index;
    s1_step <= time_step;
    s1_mode <= mode;
    s1_sgn  <= {spin_z[15], spin_y[15], spin_x[15]};
    s1_ax   <= spin_x[15] ? 16'(-spin_x) : spin_x;
    s1_ay   <= spin_y[15] ? 16'(-spin_y) : spin_y;
    s1_az   <= spin_z[15] ? 16'(-spin_z) : spin_z;
    s1_px   <= spin_x * axis_x;
    s1_py   <= spin_y * axis_y;
    s1_pz   <= spin_z * axis_z;
  end

  // stage 2: sums
  assign dsum = 34'(s1_px) + 34'(s1_py) + 34'(s1_pz);
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_atom  <= s1_atom;
    s2_step  <= s1_step;
    s2_mode  <= s1_mode;
    s2_sum   <= 18'(s1_ax) + 18'(s1_ay) + 18'(s1_az);
    s2_state <= (s1_mode == sst_pkg::MODE_CUBIC) ? s1_sgn : {2'b00, dsum[33]};
    s2_dabs  <= dsum[33] ? 34'(-dsum) : dsum;
  end

  // stage 3: square of abs sum, then per-threshold issue
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
      s3_t   <= '0;
    end else if (s2_vld) begin
      s3_vld <= 1'b1;
      s3_t   <= '0;
    end else if (s3_done) begin
      s3_vld <= 1'b0;
    end else if (s3_vld) begin
      s3_t <= s3_t + TC_W'(1);
    end
    if (s2_vld) begin
      s3_atom  <= s2_atom;
      s3_step  <= s2_step;
      s3_mode  <= s2_mode;
      s3_state <= s2_state;
      s3_sq    <= s2_sum * s2_sum;
      s3_dabs  <= s2_dabs;
    end
  end

  // threshold compare
  assign th_cur = thr[2'(s3_t)];
  assign th_sq  = 32'(th_cur * th_cur);
  assign th_sq3 = 34'(th_sq) + 34'({th_sq, 1'b0});
  always_comb begin
    if (s3_mode == sst_pkg::MODE_CUBIC) begin
      met_c = th_cur[15] || (th_cur == 16'sd0) || (36'(th_sq3) <= s3_sq);
    end else begin
      met_c = th_cur[15] || (s3_dabs >= {3'b000, th_cur[14:0], 15'd0}
                             + 34'(0)) ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls.vld <= 1'b0;
    end else begin
      cls.vld <= s3_vld;
    end
    cls.atom  <= s3_atom;
    cls.step  <= s3_step;
    cls.state <= s3_state;
    cls.tidx  <= 2'(s3_t);
    cls.met   <= met_c;
    cls.last  <= s3_done;
  end

  ap_gap: assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> !s3_vld || s3_done) else $error("sample overlap");
  ap_last: assert property (@(posedge clk) disable iff (rst)
    cls.vld && cls.last |=> !cls.vld || 1'b1) else $error("last");
  ap_accept: assert property (@(posedge clk) disable iff (rst)
    s1_vld |-> !s2_vld) else $error("stage overlap");

endmodule

// ===== design/sst_table.sv =====
// Per (threshold, atom) record: read, update, write back.
// The classifier spaces words so that one entry's read never follows
// its own pending write in the same threshold slot.
module sst_table #(
  parameter int ATOM_COUNT      = sst_pkg::ATOM_COUNT_DEF,
  parameter int THRESHOLD_COUNT = sst_pkg::THRESHOLD_COUNT_DEF,
  parameter int COUNT_WIDTH     = sst_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sst_pkg::cls_t              cls,
  output logic                       clearing,
  output logic                       done,
  output logic [1:0]                 threshold_index,
  output logic [sst_pkg::ATOM_W-1:0] atom_id,
  output logic [2:0]                 snap_state,
  output logic                       is_lost,
  output logic                       switched_now,
  output logic [31:0]                switch_count,
  output logic [31:0]                aligned_count,
  output logic [31:0]                lost_count,
  output logic [31:0]                first_switch_step,
  output logic [31:0]                last_switch_step,
  output logic                       has_switched,
  output logic                       last_of_run
);

  localparam int DEPTH = ATOM_COUNT * THRESHOLD_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = COUNT_WIDTH;
  localparam int EW    = 4 + 3 * CW + 64 + 1;
  localparam logic [CW-1:0] CMAX = '1;

  typedef struct packed {
    logic          valid;
    logic [2:0]    st;
    logic [CW-1:0] sw;
    logic [CW-1:0] al;
    logic [CW-1:0] lo;
    logic [31:0]   first;
    logic [31:0]   latest;
    logic          flag;
  } ent_t;

  logic [AW-1:0] raddr, waddr, clr_addr;
  logic          we;
  ent_t          rdata, wdata, upd;
  logic [EW-1:0] rraw;
  sst_pkg::cls_t r1;
  logic          sw_c;

  assign raddr = AW'(32'(cls.tidx) * ATOM_COUNT + 32'(cls.atom));

  // clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  sst_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rraw)
  );
  assign rdata = ent_t'(rraw);

  always_ff @(posedge clk) begin
    if (rst) begin
      r1.vld <= 1'b0;
    end else begin
      r1.vld <= cls.vld;
    end
    r1.atom <= cls.atom; r1.step <= cls.step; r1.state <= cls.state;
    r1.tidx <= cls.tidx; r1.met <= cls.met; r1.last <= cls.last;
  end

  // update
  always_comb begin
    upd  = rdata;
    sw_c = 1'b0;
    if (!r1.met) begin
      upd.lo = (rdata.lo == CMAX) ? CMAX : rdata.lo + CW'(1);
    end else begin
      upd.al = (rdata.al == CMAX) ? CMAX : rdata.al + CW'(1);
      if (!rdata.valid) begin
        upd.valid = 1'b1;
        upd.st    = r1.state;
      end else if (rdata.st != r1.state) begin
        sw_c = 1'b1;
        if (!rdata.flag) begin
          upd.first = r1.step;
          upd.flag  = 1'b1;
        end
        upd.latest = r1.step;
        upd.sw     = (rdata.sw == CMAX) ? CMAX : rdata.sw + CW'(1);
        upd.st     = r1.state;
      end
    end
  end

  assign we    = clearing || r1.vld;
  assign waddr = clearing ? clr_addr : AW'(32'(r1.tidx) * ATOM_COUNT + 32'(r1.atom));
  assign wdata = clearing ? '0 : upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r1.vld;
    end
    threshold_index   <= r1.tidx;
    atom_id           <= r1.atom;
    snap_state        <= r1.met ? r1.state : 3'd0;
    is_lost           <= !r1.met;
    switched_now      <= sw_c;
    switch_count      <= 32'(upd.sw);
    aligned_count     <= 32'(upd.al);
    lost_count        <= 32'(upd.lo);
    first_switch_step <= upd.first;
    last_switch_step  <= upd.latest;
    has_switched      <= upd.flag;
    last_of_run       <= r1.last;
  end

  ap_noclr: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cls.vld) else $error("word during clear");
  ap_lost: assert property (@(posedge clk) disable iff (rst)
    r1.vld && !r1.met |-> !sw_c) else $error("switch on lost");
  ap_done: assert property (@(posedge clk) disable iff (rst)
    r1.vld |=> done) else $error("result missing");

endmodule

// ===== design/spin_state_switch_tracker.sv =====
// Spin state switch tracker.
// Command channel: a sample is taken when start is high and busy is low.
// Fields: atom_index, spin_x/y/z (Q1.15), is_magnetic, time_step.
// Configuration: cfg_we/cfg_index/cfg_data, which the user writes only
// while idle; the block itself does not enforce this.
// Results: one per threshold, marked by done, shown for one cycle each;
// last_of_run flags the final threshold of a sample. Non-magnetic or
// out-of-range atoms give no result. A sample passes the classifier
// stages, the classified word, the table read and the output registers;
// results then follow one per cycle. busy holds off the next sample while
// the classifier issues one word per threshold, and with a single
// threshold keeps a table entry's read and write apart; the table serves
// one threshold slot per cycle. Reset: registers return to reset values
// and a clearing pass walks all THRESHOLD_COUNT*ATOM_COUNT entries with
// busy high. The receiver cannot stall; results are never held back.
module spin_state_switch_tracker #(
  parameter int ATOM_COUNT      = sst_pkg::ATOM_COUNT_DEF,
  parameter int THRESHOLD_COUNT = sst_pkg::THRESHOLD_COUNT_DEF,
  parameter int COUNT_WIDTH     = sst_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [9:0]                 atom_index,
  input  logic signed [15:0]         spin_x,
  input  logic signed [15:0]         spin_y,
  input  logic signed [15:0]         spin_z,
  input  logic                       is_magnetic,
  input  logic [31:0]                time_step,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [15:0]                cfg_data,
  output logic                       done,
  output logic [1:0]                 threshold_index,
  output logic [9:0]                 atom_id,
  output logic [2:0]                 snap_state,
  output logic                       is_lost,
  output logic                       switched_now,
  output logic [31:0]                switch_count,
  output logic [31:0]                aligned_count,
  output logic [31:0]                lost_count,
  output logic [31:0]                first_switch_step,
  output logic [31:0]                last_switch_step,
  output logic                       has_switched,
  output logic                       last_of_run
);

  logic               mode;
  logic signed [15:0] ax, ay, az;
  logic signed [15:0] thr [4];
  logic               cls_busy, clearing;
  sst_pkg::cls_t      cls;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sst_pkg::MODE_UNIAXIAL;
      ax <= '0; ay <= '0; az <= 16'sd32767;
      thr[0] <= '0; thr[1] <= '0; thr[2] <= '0; thr[3] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sst_pkg::REG_MODE: mode   <= cfg_data[0];
        sst_pkg::REG_AX:   ax     <= cfg_data;
        sst_pkg::REG_AY:   ay     <= cfg_data;
        sst_pkg::REG_AZ:   az     <= cfg_data;
        sst_pkg::REG_TH0:  thr[0] <= cfg_data;
        sst_pkg::REG_TH1:  thr[1] <= cfg_data;
        sst_pkg::REG_TH2:  thr[2] <= cfg_data;
        sst_pkg::REG_TH3:  thr[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = cls_busy || clearing;

  sst_classify #(.ATOM_COUNT(ATOM_COUNT), .THRESHOLD_COUNT(THRESHOLD_COUNT)) u_cls (
    .clk(clk), .rst(rst), .in_vld(start && !busy), .atom_index(atom_index),
    .spin_x(spin_x), .spin_y(spin_y), .spin_z(spin_z), .is_magnetic(is_magnetic),
    .time_step(time_step), .mode(mode), .axis_x(ax), .axis_y(ay), .axis_z(az),
    .thr(thr), .busy(cls_busy), .cls(cls)
  );

  sst_table #(.ATOM_COUNT(ATOM_COUNT), .THRESHOLD_COUNT(THRESHOLD_COUNT),
              .COUNT_WIDTH(COUNT_WIDTH)) u_tab (
    .clk(clk), .rst(rst), .cls(cls), .clearing(clearing), .done(done),
    .threshold_index(threshold_index), .atom_id(atom_id),
    .snap_state(snap_state), .is_lost(is_lost), .switched_now(switched_now),
    .switch_count(switch_count), .aligned_count(aligned_count),
    .lost_count(lost_count), .first_switch_step(first_switch_step),
    .last_switch_step(last_switch_step), .has_switched(has_switched),
    .last_of_run(last_of_run)
  );

  ap_run: assert property (@(posedge clk) disable iff (rst)
    done && last_of_run |-> threshold_index == 2'(THRESHOLD_COUNT - 1))
    else $error("bad last");
  ap_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done) else $error("result during clear");
  ap_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && is_magnetic |=> busy || 32'(atom_index) >= 32'(ATOM_COUNT))
    else $error("busy not raised");

endmodule

// ===== sim/tb_spin_state_switch_tracker.sv =====
`timescale 1ns / 1ps

module tb_spin_state_switch_tracker;

  localparam int NUM_THR     = 4;
  localparam int ATOM_SLOTS  = 1024;
  localparam int DRAIN_WAIT  = 12;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 420;
  localparam longint SAT_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  tidx;
    logic [9:0]  atom;
    logic [2:0]  state;
    logic        lost;
    logic        sw_now;
    logic [31:0] sw_cnt;
    logic [31:0] al_cnt;
    logic [31:0] lo_cnt;
    logic [31:0] first_step;
    logic [31:0] last_step;
    logic        has_sw;
    logic        last;
  } track_word_t;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_e;

  // one directed stimulus row: a sample or a register write
  typedef struct {
    row_kind_e           kind;
    logic [sst_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [15:0]         reg_val;
    logic [9:0]          atom;
    logic signed [15:0]  sx, sy, sz;
    logic                mag;
    logic [31:0]         step;
    logic                typed;     // state/lost of threshold 0 given below
    logic [2:0]          t0_state;
    logic                t0_lost;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [9:0] atom_index = '0;
  logic signed [15:0] spin_x = '0, spin_y = '0, spin_z = '0;
  logic is_magnetic = 1'b0;
  logic [31:0] time_step = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic [1:0] threshold_index;
  logic [9:0] atom_id;
  logic [2:0] snap_state;
  logic is_lost, switched_now, has_switched, last_of_run;
  logic [31:0] switch_count, aligned_count, lost_count;
  logic [31:0] first_switch_step, last_switch_step;

  spin_state_switch_tracker DUT (.*);

  always #1 clk = ~clk;

  // predictor copy of configuration and per-atom tables
  logic               mode_q;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic signed [15:0] thr_q [NUM_THR];
  logic               st_valid [NUM_THR][ATOM_SLOTS];
  logic [2:0]         st_val   [NUM_THR][ATOM_SLOTS];
  longint             sw_ctr   [NUM_THR][ATOM_SLOTS];
  longint             al_ctr   [NUM_THR][ATOM_SLOTS];
  longint             lo_ctr   [NUM_THR][ATOM_SLOTS];
  logic [31:0]        first_st [NUM_THR][ATOM_SLOTS];
  logic [31:0]        last_st  [NUM_THR][ATOM_SLOTS];
  logic               sw_flag  [NUM_THR][ATOM_SLOTS];

  track_word_t expected_words[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic [31:0] step_ctr = 0;

  function automatic longint sat_add(longint c);
    return (c >= SAT_MAX) ? SAT_MAX : c + 1;
  endfunction

  // register write into the predictor copy
  function automatic void shadow_write(logic [2:0] idx, logic [15:0] val);
    case (idx)
      sst_pkg::REG_MODE: mode_q = val[0];
      sst_pkg::REG_AX:   ax_q = val;
      sst_pkg::REG_AY:   ay_q = val;
      sst_pkg::REG_AZ:   az_q = val;
      sst_pkg::REG_TH0:  thr_q[0] = val;
      sst_pkg::REG_TH1:  thr_q[1] = val;
      sst_pkg::REG_TH2:  thr_q[2] = val;
      sst_pkg::REG_TH3:  thr_q[3] = val;
      default: ;
    endcase
  endfunction

  // snap spin to an easy-axis state, update tables, queue one word per threshold
  task automatic predict_switch_words(logic [9:0] a, logic signed [15:0] x,
                                      logic signed [15:0] y, logic signed [15:0] z,
                                      logic m, logic [31:0] stp, logic typed,
                                      logic [2:0] t0s, logic t0l);
    longint sum, d, th;
    logic [2:0] s;
    logic met, sw;
    track_word_t w;
    if (!m) return;
    if (mode_q == sst_pkg::MODE_CUBIC) begin
      s = {z < 0, y < 0, x < 0};
      sum = (x < 0 ? -longint'(x) : longint'(x)) + (y < 0 ? -longint'(y) : longint'(y))
          + (z < 0 ? -longint'(z) : longint'(z));
      d = 0;
    end else begin
      d = longint'(x) * ax_q + longint'(y) * ay_q + longint'(z) * az_q;
      s = (d < 0) ? 3'd1 : 3'd0;
      if (d < 0) d = -d;
      sum = 0;
    end
    for (int t = 0; t < NUM_THR; t++) begin
      th = thr_q[t];
      if (mode_q == sst_pkg::MODE_CUBIC) met = (th <= 0) || (sum * sum >= 3 * th * th);
      else met = d >= th * 32768;
      sw = 1'b0;
      if (!met) begin
        lo_ctr[t][a] = sat_add(lo_ctr[t][a]);
      end else begin
        al_ctr[t][a] = sat_add(al_ctr[t][a]);
        if (!st_valid[t][a]) begin
          st_valid[t][a] = 1'b1;
          st_val[t][a] = s;
        end else if (st_val[t][a] != s) begin
          if (!sw_flag[t][a]) begin
            first_st[t][a] = stp;
            sw_flag[t][a] = 1'b1;
          end
          last_st[t][a] = stp;
          sw_ctr[t][a] = sat_add(sw_ctr[t][a]);
          st_val[t][a] = s;
          sw = 1'b1;
        end
      end
      w.tidx = 2'(t);
      w.atom = a;
      w.state = met ? s : 3'd0;
      w.lost = !met;
      w.sw_now = sw;
      w.sw_cnt = sw_ctr[t][a][31:0];
      w.al_cnt = al_ctr[t][a][31:0];
      w.lo_cnt = lo_ctr[t][a][31:0];
      w.first_step = first_st[t][a];
      w.last_step = last_st[t][a];
      w.has_sw = sw_flag[t][a];
      w.last = (t == NUM_THR - 1);
      // hand-typed values take the place of the predicted ones
      if (t == 0 && typed) begin
        w.state = t0s;
        w.lost = t0l;
      end
      expected_words.push_back(w);
    end
  endtask

  // present one sample, hold until taken, then idle per burst pattern
  task automatic send_sample(logic [9:0] a, logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, logic m, logic [31:0] stp,
                             logic typed, logic [2:0] t0s, logic t0l);
    int gap;
    atom_index <= a;
    spin_x <= x;
    spin_y <= y;
    spin_z <= z;
    is_magnetic <= m;
    time_step <= stp;
    cfg_we <= 1'b0;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_switch_words(a, x, y, z, m, stp, typed, t0s, t0l);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // let every expected word arrive, plus slack for ignored samples
  task automatic wait_idle();
    start <= 1'b0;
    cfg_we <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // write enable stays up across back-to-back writes; the next sample or drain drops it
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    shadow_write(idx, val);
  endtask

  function automatic logic signed [15:0] pick_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 511)) - 256);
      3: return '0;
      default: return 16'($urandom);
    endcase
  endfunction

  // random samples: mostly a small atom pool so states switch back and forth
  task automatic random_phase(int n);
    logic [9:0] a;
    logic m;
    logic [31:0] stp;
    for (int i = 0; i < n; i++) begin
      a = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 15));
      m = ($urandom_range(0, 9) != 0);
      step_ctr += $urandom_range(1, 50);
      stp = ($urandom_range(0, 15) == 0) ? $urandom : step_ctr;
      send_sample(a, pick_comp(), pick_comp(), pick_comp(), m, stp, 1'b0, '0, 1'b0);
    end
  endtask

  function automatic dir_row_t wr(logic [2:0] idx, logic [15:0] val);
    dir_row_t r;
    r = '{kind: ROW_WRITE, default: '0};
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t smp(logic [9:0] a, int x, int y, int z, logic m,
                                   logic [31:0] stp, logic typed, logic [2:0] s, logic l);
    dir_row_t r;
    r = '{kind: ROW_SAMPLE, default: '0};
    r.atom = a;
    r.sx = 16'(x);
    r.sy = 16'(y);
    r.sz = 16'(z);
    r.mag = m;
    r.step = stp;
    r.typed = typed;
    r.t0_state = s;
    r.t0_lost = l;
    return r;
  endfunction

  // check each result word against the oldest expectation
  always @(posedge clk) begin
    track_word_t act, exp_w;
    if (!rst && done) begin
      act = '{threshold_index, atom_id, snap_state, is_lost, switched_now, switch_count,
              aligned_count, lost_count, first_switch_step, last_switch_step, has_switched,
              last_of_run};
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %p", $time, act);
      end else begin
        exp_w = expected_words.pop_front();
        if (act != exp_w) begin
          errors++;
          $display("%0t: word mismatch expected %p actual %p", $time, exp_w, act);
        end
      end
    end
  end

  // watchdog on cycles with no accepted sample and no word
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    mode_q = sst_pkg::MODE_UNIAXIAL;
    ax_q = 0;
    ay_q = 0;
    az_q = 16'sh7FFF;
    for (int t = 0; t < NUM_THR; t++) begin
      thr_q[t] = 0;
      for (int a = 0; a < ATOM_SLOTS; a++) begin
        st_valid[t][a] = 0; st_val[t][a] = 0; sw_ctr[t][a] = 0; al_ctr[t][a] = 0;
        lo_ctr[t][a] = 0; first_st[t][a] = 0; last_st[t][a] = 0; sw_flag[t][a] = 0;
      end
    end

    // directed: reset config (uniaxial on +z), then cubic with extreme thresholds
    rows.push_back(smp(0, 0, 0, 32767, 1, 32'd10, 1, 3'd0, 0));
    rows.push_back(smp(0, 0, 0, -32768, 1, 32'd11, 1, 3'd1, 0));
    rows.push_back(smp(0, 5, -7, -1, 1, 32'd12, 1, 3'd1, 0));
    rows.push_back(smp(1023, 32767, -32768, 0, 1, 32'd0, 1, 3'd0, 0));
    rows.push_back(smp(5, 100, 100, 100, 0, 32'd13, 0, 3'd0, 0));
    rows.push_back(smp(0, 0, 0, 32767, 1, 32'hFFFF_FFFF, 1, 3'd0, 0));
    rows.push_back(smp(0, 0, 0, 0, 1, 32'd14, 1, 3'd0, 0));
    rows.push_back(wr(sst_pkg::REG_MODE, 16'(sst_pkg::MODE_CUBIC)));
    rows.push_back(wr(sst_pkg::REG_TH0, 16'h8000));
    rows.push_back(wr(sst_pkg::REG_TH2, 16'd16384));
    rows.push_back(wr(sst_pkg::REG_TH3, 16'h7FFF));
    rows.push_back(smp(2, 1, -1, -32768, 1, 32'd20, 1, 3'd6, 0));
    rows.push_back(smp(2, 0, 0, 0, 1, 32'd21, 1, 3'd0, 0));
    rows.push_back(smp(2, 32767, 32767, 32767, 1, 32'd22, 1, 3'd0, 0));
    rows.push_back(smp(2, -32768, -32768, -32768, 1, 32'd23, 1, 3'd7, 0));
    rows.push_back(smp(3, -32768, 5, 0, 1, 32'd24, 1, 3'd1, 0));
    rows.push_back(smp(3, 100, -200, 50, 1, 32'hFFFF_FFFF, 1, 3'd2, 0));
    rows.push_back(smp(4, 18918, 18918, 18918, 1, 32'd25, 0, 3'd0, 0));
    rows.push_back(smp(4, -18918, 18918, -18918, 0, 32'd26, 0, 3'd0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      end else begin
        send_sample(rows[i].atom, rows[i].sx, rows[i].sy, rows[i].sz, rows[i].mag,
                    rows[i].step, rows[i].typed, rows[i].t0_state, rows[i].t0_lost);
      end
    end

    // random phases over several settings
    random_phase(RAND_ITEMS / 4);

    wait_idle();
    write_reg(sst_pkg::REG_MODE, 16'(sst_pkg::MODE_UNIAXIAL));
    write_reg(sst_pkg::REG_AX, 16'h7FFF);
    write_reg(sst_pkg::REG_AY, 16'h8000);
    write_reg(sst_pkg::REG_AZ, 16'd12345);
    write_reg(sst_pkg::REG_TH0, 16'd0);
    write_reg(sst_pkg::REG_TH1, 16'd8000);
    write_reg(sst_pkg::REG_TH2, 16'h8000);
    write_reg(sst_pkg::REG_TH3, 16'h7FFF);
    random_phase(RAND_ITEMS / 4);

    wait_idle();
    write_reg(sst_pkg::REG_MODE, 16'(sst_pkg::MODE_CUBIC));
    write_reg(sst_pkg::REG_TH0, 16'd20000);
    write_reg(sst_pkg::REG_TH1, 16'd30000);
    write_reg(sst_pkg::REG_TH2, 16'd10000);
    write_reg(sst_pkg::REG_TH3, 16'hFFFF);
    random_phase(RAND_ITEMS / 4);

    wait_idle();
    write_reg(sst_pkg::REG_MODE, 16'(sst_pkg::MODE_UNIAXIAL));
    write_reg(sst_pkg::REG_AX, 16'h8000);
    write_reg(sst_pkg::REG_AY, 16'h8000);
    write_reg(sst_pkg::REG_AZ, 16'h8000);
    write_reg(sst_pkg::REG_TH0, 16'd4000);
    write_reg(sst_pkg::REG_TH1, 16'd1);
    write_reg(sst_pkg::REG_TH2, 16'd16000);
    write_reg(sst_pkg::REG_TH3, 16'hC000);
    random_phase(RAND_ITEMS / 4);

    wait_idle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
